// ===== hw/rtl/bounded_queue_batcher_with_drop_defines.svh =====
// assertion macros for the bounded queue batcher
// used by the modules that carry concurrent checks; expects clk and rst in scope
`ifndef BOUNDED_QUEUE_BATCHER_WITH_DROP_DEFINES_SVH
`define BOUNDED_QUEUE_BATCHER_WITH_DROP_DEFINES_SVH

// same-cycle implication check
`define BQB_CHK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication check
`define BQB_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/bqb_pkg.sv =====
// shared types and constants of the bounded queue batcher
// no dependencies
package bqb_pkg;

  localparam int DEPTH_DEF = 1024;

  // result status codes
  localparam logic [2:0] ST_QUEUED  = 3'd0;
  localparam logic [2:0] ST_REJECT  = 3'd1;
  localparam logic [2:0] ST_EMPTY   = 3'd2;
  localparam logic [2:0] ST_HEADDROP = 3'd3;
  localparam logic [2:0] ST_SENT    = 3'd4;
  localparam logic [2:0] ST_FAIL    = 3'd5;

  // action codes
  localparam logic ACT_ENQ   = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // register indexes
  localparam logic [2:0] REG_BATCH_LIMIT = 3'd0;
  localparam logic [2:0] REG_QUEUE_BYTES = 3'd1;
  localparam logic [2:0] REG_QUEUE_ENTRIES = 3'd2;
  localparam logic [2:0] REG_DROP_NEWEST = 3'd3;

  // register reset values
  localparam logic [23:0] BATCH_LIMIT_RST = 24'd262144;
  localparam logic [31:0] QUEUE_BYTES_RST = 32'd5242880;
  localparam logic [10:0] QUEUE_ENTRIES_RST = 11'd1024;

  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

  // one queued command word
  typedef struct packed {
    logic        act;
    logic [24:0] rec;
    logic        ok;
  } cmd_t;

  // configuration registers
  typedef struct packed {
    logic [23:0] batch_limit;
    logic [31:0] queue_bytes;
    logic [10:0] queue_entries;
    logic        drop_newest;
  } cfg_t;

endpackage

// ===== hw/rtl/bqb_ram.sv =====
// generic single write, single read RAM with registered read data
// no dependencies
module bqb_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/bqb_front.sv =====
// front end: takes command words and holds them in a two-entry queue
// depends on bqb_pkg
module bqb_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             action,
  input  logic [23:0]      line_len,
  input  logic             post_ok,
  output logic             busy,
  output logic             cmd_valid,
  output bqb_pkg::cmd_t    cmd,
  input  logic             cmd_pop
);

  bqb_pkg::cmd_t q [2];
  logic          wp;
  logic          rp;
  logic [1:0]    n;
  logic          push;
  bqb_pkg::cmd_t word;

  assign busy      = (n == 2'd2);
  assign push      = start && !busy;
  assign cmd_valid = (n != 2'd0);
  assign cmd       = q[rp];

  // classify: the record length carries the terminator byte
  always_comb begin
    word.act = action;
    word.rec = {1'b0, line_len} + 25'd1;
    word.ok  = post_ok;
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= word;
    end
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      n  <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (cmd_pop) rp <= ~rp;
      n <= n + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule

// ===== hw/rtl/bqb_back.sv =====
// back end: queue bookkeeping, store walks for eviction and flush, counters
// depends on bqb_pkg, bqb_ram and the assertion macro header
`include "bounded_queue_batcher_with_drop_defines.svh"

module bqb_back #(
  parameter int DEPTH = bqb_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  bqb_pkg::cfg_t       cfg,
  input  logic                cmd_valid,
  input  bqb_pkg::cmd_t       cmd,
  output logic                cmd_pop,
  output logic                done,
  output logic [2:0]          status,
  output logic [10:0]         batch_lines,
  output logic [23:0]         batch_size,
  output logic [10:0]         queued_lines,
  output logic [31:0]         queued_total,
  output logic [31:0]         dropped_lines,
  output logic [47:0]         dropped_total,
  output logic [31:0]         sent_count,
  output logic [47:0]         sent_total,
  output logic [31:0]         failed_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > 11) ? CW : 11;
  localparam logic [CW:0] DEPTH_W = (CW + 1)'(DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ENQ  = 3'd1;
  localparam logic [2:0] S_EVA  = 3'd2;
  localparam logic [2:0] S_EVB  = 3'd3;
  localparam logic [2:0] S_FLA  = 3'd4;
  localparam logic [2:0] S_FLB  = 3'd5;

  logic [2:0]    state;
  bqb_pkg::cmd_t cur;
  logic [AW-1:0] head;
  logic [AW-1:0] rdp;
  logic [CW-1:0] cnt;
  logic [CW-1:0] idx;
  logic [23:0]   sum;
  logic [31:0]   bytes;
  logic [31:0]   dl;
  logic [47:0]   db;
  logic [31:0]   sc;
  logic [47:0]   sb;
  logic [31:0]   fc;

  logic          ram_we;
  logic [AW-1:0] tail;
  logic [24:0]   rdata;

  function automatic logic [AW-1:0] wrap(input logic [CW:0] v);
    logic [CW:0] r;
    r = (v >= DEPTH_W) ? v - DEPTH_W : v;
    return r[AW-1:0];
  endfunction

  // entry limit clipped to the store depth, and the room check
  logic [LW-1:0] lim;
  logic          no_room;
  logic          too_big;
  always_comb begin
    lim = (LW'(cfg.queue_entries) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(cfg.queue_entries);
    no_room = (LW'(cnt) >= lim) ||
              (({1'b0, bytes} + 33'(cur.rec)) > {1'b0, cfg.queue_bytes});
    too_big = cur.rec > {1'b0, cfg.batch_limit};
  end

  // flush prefix step
  logic [25:0]   fl_tot;
  logic          fl_fit;
  logic [CW-1:0] fl_n;
  logic [23:0]   fl_s;
  logic          fl_end;
  always_comb begin
    fl_tot = {2'b00, sum} + {1'b0, rdata};
    fl_fit = fl_tot <= {2'b00, cfg.batch_limit};
    fl_n   = fl_fit ? idx + CW'(1) : idx;
    fl_s   = fl_fit ? fl_tot[23:0] : sum;
    fl_end = !fl_fit || (idx + CW'(1) == cnt);
  end

  // head advance and pointer arithmetic
  logic [CW-1:0] pop_n;
  logic [AW-1:0] head_adv;
  logic [AW-1:0] rdp_inc;
  always_comb begin
    pop_n    = (state == S_FLB && fl_n != '0) ? fl_n : CW'(1);
    head_adv = wrap((CW + 1)'(head) + (CW + 1)'(pop_n));
    rdp_inc  = wrap((CW + 1)'(rdp) + (CW + 1)'(1));
    tail     = wrap((CW + 1)'(head) + (CW + 1)'(cnt));
  end

  // saturating counter steps
  logic [24:0] drop_len;
  logic [48:0] db_sum;
  logic [48:0] sb_sum;
  logic [31:0] dl_inc;
  logic [47:0] db_inc;
  logic [31:0] sc_inc;
  logic [47:0] sb_inc;
  logic [31:0] fc_inc;
  always_comb begin
    drop_len = (state == S_EVB || state == S_FLB) ? rdata : cur.rec;
    db_sum   = {1'b0, db} + 49'(drop_len);
    sb_sum   = {1'b0, sb} + 49'(fl_s);
    dl_inc   = (dl == bqb_pkg::MAX32) ? dl : dl + 32'd1;
    db_inc   = db_sum[48] ? bqb_pkg::MAX48 : db_sum[47:0];
    sc_inc   = (sc == bqb_pkg::MAX32) ? sc : sc + 32'd1;
    sb_inc   = sb_sum[48] ? bqb_pkg::MAX48 : sb_sum[47:0];
    fc_inc   = (fc == bqb_pkg::MAX32) ? fc : fc + 32'd1;
  end

  assign cmd_pop = (state == S_IDLE) && cmd_valid;
  assign ram_we  = (state == S_ENQ) && !too_big && !no_room;

  bqb_ram #(.WIDTH(25), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata (cur.rec),
    .raddr (rdp),
    .rdata (rdata)
  );

  // command word held while it is carried out
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head        <= '0;
      rdp         <= '0;
      cnt         <= '0;
      idx         <= '0;
      sum         <= '0;
      bytes       <= '0;
      dl          <= '0;
      db          <= '0;
      sc          <= '0;
      sb          <= '0;
      fc          <= '0;
      done        <= 1'b0;
      status      <= bqb_pkg::ST_QUEUED;
      batch_lines <= '0;
      batch_size  <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            if (cmd.act == bqb_pkg::ACT_ENQ) begin
              state <= S_ENQ;
            end else if (cnt == '0) begin
              done        <= 1'b1;
              status      <= bqb_pkg::ST_EMPTY;
              batch_lines <= '0;
              batch_size  <= '0;
            end else begin
              rdp   <= head;
              idx   <= '0;
              sum   <= '0;
              state <= S_FLA;
            end
          end
        end
        S_ENQ: begin
          batch_lines <= '0;
          batch_size  <= '0;
          if (too_big || (no_room && (cnt == '0 || cfg.drop_newest))) begin
            dl     <= dl_inc;
            db     <= db_inc;
            done   <= 1'b1;
            status <= bqb_pkg::ST_REJECT;
            state  <= S_IDLE;
          end else if (no_room) begin
            rdp   <= head;
            state <= S_EVA;
          end else begin
            cnt    <= cnt + CW'(1);
            bytes  <= bytes + 32'(cur.rec);
            done   <= 1'b1;
            status <= bqb_pkg::ST_QUEUED;
            state  <= S_IDLE;
          end
        end
        S_EVA: begin
          state <= S_EVB;
        end
        S_EVB: begin
          dl    <= dl_inc;
          db    <= db_inc;
          head  <= head_adv;
          cnt   <= cnt - CW'(1);
          bytes <= bytes - 32'(rdata);
          state <= S_ENQ;
        end
        S_FLA: begin
          state <= S_FLB;
        end
        S_FLB: begin
          if (!fl_end) begin
            idx   <= fl_n;
            sum   <= fl_s;
            rdp   <= rdp_inc;
            state <= S_FLA;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
            if (fl_n == '0) begin
              // head record alone exceeds the batch limit
              dl          <= dl_inc;
              db          <= db_inc;
              head        <= head_adv;
              cnt         <= cnt - CW'(1);
              bytes       <= bytes - 32'(rdata);
              status      <= bqb_pkg::ST_HEADDROP;
              batch_lines <= '0;
              batch_size  <= '0;
            end else begin
              batch_lines <= 11'(fl_n);
              batch_size  <= fl_s;
              if (cur.ok) begin
                head   <= head_adv;
                cnt    <= cnt - fl_n;
                bytes  <= bytes - 32'(fl_s);
                sc     <= sc_inc;
                sb     <= sb_inc;
                status <= bqb_pkg::ST_SENT;
              end else begin
                fc     <= fc_inc;
                status <= bqb_pkg::ST_FAIL;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign queued_lines  = 11'(cnt);
  assign queued_total  = bytes;
  assign dropped_lines = dl;
  assign dropped_total = db;
  assign sent_count    = sc;
  assign sent_total    = sb;
  assign failed_count  = fc;

  // checks
  `BQB_CHK(a_cnt_depth, 1'b1, (CW + 1)'(cnt) <= DEPTH_W, "entry count above store depth")
  `BQB_CHK(a_done_idle, done, state == S_IDLE, "result strobe outside idle")
  `BQB_CHK_NEXT(a_pop_leaves, cmd_pop, state != S_IDLE || done, "accepted word not started")

endmodule

// ===== hw/rtl/bounded_queue_batcher_with_drop.sv =====
// top level of the bounded record queue with batch flush and drop policy
// depends on bqb_pkg, bqb_front, bqb_back
//
// channel  | direction | handshake          | payload
// command  | in        | start, busy        | action, line_len, post_ok
// result   | out       | done (one cycle)   | status .. failed_count
// config   | in        | cfg_we             | cfg_idx, cfg_data
//
// an enqueue word goes through S_ENQ, and through S_EVA, S_EVB and S_ENQ again per record evicted
// a flush word goes through S_FLA and S_FLB for each record walked
// in the length store (one read port, registered read data)
// a two-word command queue sits in front; busy is high while it is full
// reset is synchronous; the length store needs no clearing pass
// results are strobed for one cycle and cannot be held off
module bounded_queue_batcher_with_drop #(
  parameter int DEPTH = bqb_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [23:0] line_len,
  input  logic        post_ok,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic [2:0]  status,
  output logic [10:0] batch_lines,
  output logic [23:0] batch_size,
  output logic [10:0] queued_lines,
  output logic [31:0] queued_total,
  output logic [31:0] dropped_lines,
  output logic [47:0] dropped_total,
  output logic [31:0] sent_count,
  output logic [47:0] sent_total,
  output logic [31:0] failed_count
);

  bqb_pkg::cfg_t cfg;
  bqb_pkg::cmd_t cmd;
  logic          cmd_valid;
  logic          cmd_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.batch_limit   <= bqb_pkg::BATCH_LIMIT_RST;
      cfg.queue_bytes   <= bqb_pkg::QUEUE_BYTES_RST;
      cfg.queue_entries <= bqb_pkg::QUEUE_ENTRIES_RST;
      cfg.drop_newest   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        bqb_pkg::REG_BATCH_LIMIT:   cfg.batch_limit   <= cfg_data[23:0];
        bqb_pkg::REG_QUEUE_BYTES:   cfg.queue_bytes   <= cfg_data;
        bqb_pkg::REG_QUEUE_ENTRIES: cfg.queue_entries <= cfg_data[10:0];
        bqb_pkg::REG_DROP_NEWEST:   cfg.drop_newest   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  bqb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .action    (action),
    .line_len  (line_len),
    .post_ok   (post_ok),
    .busy      (busy),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  bqb_back #(.DEPTH(DEPTH)) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .done          (done),
    .status        (status),
    .batch_lines   (batch_lines),
    .batch_size    (batch_size),
    .queued_lines  (queued_lines),
    .queued_total  (queued_total),
    .dropped_lines (dropped_lines),
    .dropped_total (dropped_total),
    .sent_count    (sent_count),
    .sent_total    (sent_total),
    .failed_count  (failed_count)
  );

endmodule

// ===== bench/bqb_checker.sv =====
// result checker for the bounded record queue batcher
// watches command, config and result channels; depends on bqb_pkg
module bqb_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        action,
  input  logic [23:0] line_len,
  input  logic        post_ok,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_data,
  input  logic        done,
  input  logic [2:0]  status,
  input  logic [10:0] batch_lines,
  input  logic [23:0] batch_size,
  input  logic [10:0] queued_lines,
  input  logic [31:0] queued_total,
  input  logic [31:0] dropped_lines,
  input  logic [47:0] dropped_total,
  input  logic [31:0] sent_count,
  input  logic [47:0] sent_total,
  input  logic [31:0] failed_count,
  output int          errors,
  output int          pending
);
  import bqb_pkg::*;

  localparam int STORE_DEPTH = DEPTH_DEF;

  typedef struct packed {
    logic [2:0]  st;
    logic [10:0] lines;
    logic [23:0] size;
    logic [10:0] qlines;
    logic [31:0] qtotal;
    logic [31:0] dlines;
    logic [47:0] dtotal;
    logic [31:0] scount;
    logic [47:0] stotal;
    logic [31:0] fcount;
  } queue_result_t;

  // shadow of the queue and its counters
  logic [24:0] rec_len [STORE_DEPTH];
  logic [9:0]  head;
  logic [10:0] n_rec;
  logic [31:0] n_bytes;
  logic [31:0] drop_lines;
  logic [47:0] drop_bytes;
  logic [31:0] batch_ctr;
  logic [47:0] batch_byte_ctr;
  logic [31:0] refused;

  // shadow of the config registers
  logic [23:0] lim_batch;
  logic [31:0] lim_bytes;
  logic [10:0] lim_entries;
  logic        newest_policy;

  queue_result_t expected_words[$];

  function automatic logic [31:0] sat32(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? MAX32 : s[31:0];
  endfunction

  function automatic logic [47:0] sat48(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? MAX48 : s[47:0];
  endfunction

  task automatic count_drop(input logic [24:0] len);
    drop_lines = sat32(drop_lines, 32'd1);
    drop_bytes = sat48(drop_bytes, {23'd0, len});
  endtask

  task automatic pop_records(input logic [10:0] n, input logic [31:0] bytes);
    head = head + n[9:0];
    n_rec = n_rec - n;
    n_bytes = n_bytes - bytes;
  endtask

  task automatic evict_oldest();
    logic [24:0] len;
    len = rec_len[head];
    count_drop(len);
    pop_records(11'd1, {7'd0, len});
  endtask

  function automatic logic over_limits(logic [24:0] rec, logic [10:0] lim);
    return (n_rec >= lim) || (({1'b0, n_bytes} + {8'd0, rec}) > {1'b0, lim_bytes});
  endfunction

  // predicts the result of one accepted command word
  task automatic predict_word(input logic act, input logic [23:0] len_in, input logic ok,
                              output queue_result_t r);
    logic [24:0] rec;
    logic [10:0] lim;
    logic [10:0] taken;
    logic [35:0] sum;
    logic        fits;
    r = '0;
    if (act == ACT_ENQ) begin
      rec = {1'b0, len_in} + 25'd1;
      lim = (lim_entries > 11'(STORE_DEPTH)) ? 11'(STORE_DEPTH) : lim_entries;
      r.st = ST_QUEUED;
      if (rec > {1'b0, lim_batch}) begin
        count_drop(rec);
        r.st = ST_REJECT;
      end else begin
        // make room from the head or refuse the newcomer
        while (r.st == ST_QUEUED && over_limits(rec, lim) && n_rec > 0) begin
          if (newest_policy) begin
            count_drop(rec);
            r.st = ST_REJECT;
          end else begin
            evict_oldest();
          end
        end
        if (r.st == ST_QUEUED) begin
          if (over_limits(rec, lim)) begin
            count_drop(rec);
            r.st = ST_REJECT;
          end else begin
            rec_len[head + n_rec[9:0]] = rec;
            n_rec = n_rec + 11'd1;
            n_bytes = n_bytes + {7'd0, rec};
          end
        end
      end
    end else if (n_rec == 0) begin
      r.st = ST_EMPTY;
    end else begin
      // longest head prefix within the batch limit
      taken = 0;
      sum = 0;
      fits = 1'b1;
      while (fits && taken < n_rec) begin
        if (sum + {11'd0, rec_len[head + taken[9:0]]} > {12'd0, lim_batch}) begin
          fits = 1'b0;
        end else begin
          sum = sum + {11'd0, rec_len[head + taken[9:0]]};
          taken = taken + 11'd1;
        end
      end
      if (taken == 0) begin
        evict_oldest();
        r.st = ST_HEADDROP;
      end else begin
        r.lines = taken;
        r.size = sum[23:0];
        if (!ok) begin
          refused = sat32(refused, 32'd1);
          r.st = ST_FAIL;
        end else begin
          pop_records(taken, sum[31:0]);
          batch_ctr = sat32(batch_ctr, 32'd1);
          batch_byte_ctr = sat48(batch_byte_ctr, {12'd0, sum});
          r.st = ST_SENT;
        end
      end
    end
    r.qlines = n_rec;
    r.qtotal = n_bytes;
    r.dlines = drop_lines;
    r.dtotal = drop_bytes;
    r.scount = batch_ctr;
    r.stotal = batch_byte_ctr;
    r.fcount = refused;
  endtask

  task automatic check_field(input string name, input logic [47:0] exp_v,
                             input logic [47:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      errors = errors + 1;
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    queue_result_t want;
    queue_result_t got;
    if (rst) begin
      head = 0;
      n_rec = 0;
      n_bytes = 0;
      drop_lines = 0;
      drop_bytes = 0;
      batch_ctr = 0;
      batch_byte_ctr = 0;
      refused = 0;
      lim_batch = BATCH_LIMIT_RST;
      lim_bytes = QUEUE_BYTES_RST;
      lim_entries = QUEUE_ENTRIES_RST;
      newest_policy = 1'b0;
      expected_words.delete();
    end else begin
      // compare a finished word with the oldest expectation
      if (done) begin
        if (expected_words.size() == 0) begin
          $error("result word with no expectation pending, status %0d", status);
          errors = errors + 1;
        end else begin
          want = expected_words.pop_front();
          got = '{status, batch_lines, batch_size, queued_lines, queued_total,
                  dropped_lines, dropped_total, sent_count, sent_total, failed_count};
          check_field("status", 48'(want.st), 48'(got.st));
          check_field("batch_lines", 48'(want.lines), 48'(got.lines));
          check_field("batch_size", 48'(want.size), 48'(got.size));
          check_field("queued_lines", 48'(want.qlines), 48'(got.qlines));
          check_field("queued_total", 48'(want.qtotal), 48'(got.qtotal));
          check_field("dropped_lines", 48'(want.dlines), 48'(got.dlines));
          check_field("dropped_total", want.dtotal, got.dtotal);
          check_field("sent_count", 48'(want.scount), 48'(got.scount));
          check_field("sent_total", want.stotal, got.stotal);
          check_field("failed_count", 48'(want.fcount), 48'(got.fcount));
        end
      end
      // register writes
      if (cfg_we) begin
        case (cfg_idx)
          REG_BATCH_LIMIT:   lim_batch = cfg_data[23:0];
          REG_QUEUE_BYTES:   lim_bytes = cfg_data;
          REG_QUEUE_ENTRIES: lim_entries = cfg_data[10:0];
          REG_DROP_NEWEST:   newest_policy = cfg_data[0];
          default: ;
        endcase
      end
      // accepted command word
      if (start && !busy) begin
        predict_word(action, line_len, post_ok, want);
        expected_words.push_back(want);
      end
    end
    pending = expected_words.size();
  end

  final begin
    if (expected_words.size() != 0)
      $error("%0d expected result words never arrived", expected_words.size());
  end

endmodule

// ===== bench/tb_bounded_queue_batcher_with_drop.sv =====
// stimulus and verdict for the bounded record queue batcher
// depends on bqb_pkg, bounded_queue_batcher_with_drop and bqb_checker
module tb_bounded_queue_batcher_with_drop;
  import bqb_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam logic [23:0] LEN_MAX = 24'd16777214;
  localparam int IDLE_LIMIT = 40000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        action = ACT_ENQ;
  logic [23:0] line_len = '0;
  logic        post_ok = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = REG_BATCH_LIMIT;
  logic [31:0] cfg_data = '0;
  logic        busy;
  logic        done;
  logic [2:0]  status;
  logic [10:0] batch_lines;
  logic [23:0] batch_size;
  logic [10:0] queued_lines;
  logic [31:0] queued_total;
  logic [31:0] dropped_lines;
  logic [47:0] dropped_total;
  logic [31:0] sent_count;
  logic [47:0] sent_total;
  logic [31:0] failed_count;
  int          errors;
  int          pending;
  int          idle_cycles = 0;
  logic        burst_mode = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bounded_queue_batcher_with_drop dut (.*);

  bqb_checker u_checker (.*);

  // watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // issue one command word after a gap, hold until accepted
  task automatic send_word(input logic act, input logic [23:0] len, input logic ok);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    action <= act;
    line_len <= len;
    post_ok <= ok;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [23:0] batch, input logic [31:0] qbytes,
                            input logic [10:0] entries, input logic newest);
    wait_idle();
    write_reg(REG_BATCH_LIMIT, {8'd0, batch});
    write_reg(REG_QUEUE_BYTES, qbytes);
    write_reg(REG_QUEUE_ENTRIES, {21'd0, entries});
    write_reg(REG_DROP_NEWEST, {31'd0, newest});
  endtask

  function automatic logic [23:0] pick_len(int unsigned typical);
    case ($urandom_range(0, 15))
      0:       return LEN_MAX;
      1:       return 24'($urandom_range(0, 16777214));
      default: return 24'($urandom_range(0, typical));
    endcase
  endfunction

  // mostly enqueues, flushes now and then, downstream refusing some
  task automatic random_words(input int count, input int unsigned typical);
    for (int i = 0; i < count; i++) begin
      if (i % 25 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 6)
        send_word(ACT_ENQ, pick_len(typical), 1'($urandom));
      else
        send_word(ACT_FLUSH, 24'($urandom), $urandom_range(0, 3) != 0);
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: limits, rejection, eviction, refused and accepted flushes
    set_config(24'd100, 32'd300, 11'd4, 1'b0);
    send_word(ACT_FLUSH, '0, 1'b1);
    send_word(ACT_ENQ, 24'd0, 1'b0);
    send_word(ACT_ENQ, 24'd99, 1'b0);
    send_word(ACT_ENQ, 24'd100, 1'b0);
    send_word(ACT_ENQ, LEN_MAX, 1'b0);
    send_word(ACT_ENQ, 24'd49, 1'b0);
    send_word(ACT_ENQ, 24'd49, 1'b0);
    send_word(ACT_ENQ, 24'd9, 1'b0);
    send_word(ACT_FLUSH, '0, 1'b0);
    send_word(ACT_FLUSH, '0, 1'b1);
    // drop-newest with full queue, ignored register index
    set_config(24'd100, 32'd120, 11'd3, 1'b1);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_word(ACT_ENQ, 24'd59, 1'b0);
    send_word(ACT_ENQ, 24'd59, 1'b0);
    send_word(ACT_ENQ, 24'd10, 1'b0);
    // oversize head after the batch limit shrinks
    set_config(24'd50, 32'd120, 11'd3, 1'b1);
    send_word(ACT_FLUSH, '0, 1'b1);
    // zero entry limit under both policies
    set_config(24'd50, 32'd120, 11'd0, 1'b1);
    send_word(ACT_ENQ, 24'd3, 1'b0);
    set_config(24'd50, 32'd120, 11'd0, 1'b0);
    send_word(ACT_ENQ, 24'd3, 1'b0);
    // byte limit below the record
    set_config(24'd50, 32'd5, 11'd4, 1'b0);
    send_word(ACT_ENQ, 24'd2, 1'b0);
    send_word(ACT_ENQ, 24'd9, 1'b0);
    // zero batch limit
    set_config(24'd0, 32'd300, 11'd2047, 1'b0);
    send_word(ACT_ENQ, 24'd0, 1'b0);
    send_word(ACT_FLUSH, '0, 1'b1);
    send_word(ACT_FLUSH, '0, 1'b0);

    // random phases over a spread of settings
    set_config(24'hFF_FFFF, 32'hFFFF_FFFF, 11'd1024, 1'b0);
    random_words(220, 2000);
    set_config(24'd1000, 32'd5000, 11'd16, 1'b1);
    random_words(220, 300);
    set_config(24'd1, 32'd1, 11'd1, 1'b0);
    random_words(150, 2);
    set_config(BATCH_LIMIT_RST, QUEUE_BYTES_RST, 11'd2047, 1'b1);
    random_words(220, 100000);
    set_config(24'd500, 32'd2000, 11'd8, 1'b0);
    random_words(220, 200);
    set_config(24'd0, 32'd300, 11'd4, 1'b0);
    random_words(60, 50);
    set_config(24'd64, 32'hFFFF_FFFF, 11'd1024, 1'b1);
    random_words(120, 40);

    wait_idle();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/bqb_pkg.sv
hw/rtl/bqb_ram.sv
hw/rtl/bqb_front.sv
hw/rtl/bqb_back.sv
hw/rtl/bounded_queue_batcher_with_drop.sv
bench/bqb_checker.sv
bench/tb_bounded_queue_batcher_with_drop.sv
